// ===== rtl/line_pattern_search_unit_macros.svh =====
// Assertion macros used by the line pattern search back end.
`ifndef LINE_PATTERN_SEARCH_UNIT_MACROS_SVH
`define LINE_PATTERN_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LPS_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define LPS_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

// ===== rtl/lps_pkg.sv =====
// Shared types and constants of the line pattern search unit.
package lps_pkg;

  localparam int MaxPatternDefault = 16;
  localparam int CountWidthDefault = 32;
  localparam int PatternBits = 128;
  localparam int CfgDataWidth = 64;
  localparam int OutWidth = 32;
  localparam int QueueDepth = 2;
  localparam logic [7:0] NEWLINE = 8'd10;

  typedef enum logic [1:0] {
    CFG_SEARCH_MODE    = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_PATTERN_LOW    = 2'd2,
    CFG_PATTERN_HIGH   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    MODE_FIND  = 1'b0,
    MODE_COUNT = 1'b1
  } search_mode_t;

  typedef enum logic {
    KIND_FIND  = 1'b0,
    KIND_COUNT = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic newline;
    logic eof;
    logic hit;
  } scan_op_t;

endpackage

// ===== rtl/lps_text_if.sv =====
// Input channel carrying one text byte and its end-of-file flag.
interface lps_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_file;

  modport source (output valid, text_byte, end_of_file, input ready);
  modport sink (input valid, text_byte, end_of_file, output ready);
endinterface

// ===== rtl/lps_result_if.sv =====
// Output channel carrying one search result.
interface lps_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] line_number;
  logic [31:0] occurrence_count;

  modport source (output valid, result_kind, line_number, occurrence_count, input ready);
  modport sink (input valid, result_kind, line_number, occurrence_count, output ready);
endinterface

// ===== rtl/line_pattern_search_unit.sv =====
// Top level of the line pattern search unit: configuration registers and the three stages.
//
//   port     | dir | role
//   ---------+-----+------------------------------------------------
//   text     | in  | one text byte per transfer, end-of-file flag
//   result   | out | first matching line number or total count
//   cfg_*    | in  | register writes: mode, length, pattern bytes
//
// One byte is taken every cycle unless the queue is full; the byte passes through the queue and the result register.
// The front end compares the last pattern-length bytes of the window against the pattern in the cycle a byte arrives.
// A two-entry queue separates the front end from the counter and output stage.
// Input stalls only when that queue is full, which happens only while the result is not taken.
// Synchronous reset clears all line state directly; there is no clearing pass.
module line_pattern_search_unit #(
  parameter int MAX_PATTERN = lps_pkg::MaxPatternDefault,
  parameter int COUNT_WIDTH = lps_pkg::CountWidthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  lps_text_if.sink                         text,
  lps_result_if.source                     result,
  input  logic                             cfg_write,
  input  lps_pkg::cfg_index_t              cfg_index,
  input  logic [lps_pkg::CfgDataWidth-1:0] cfg_data
);
  import lps_pkg::*;

  search_mode_t            search_mode;
  logic [4:0]              pattern_length;
  logic [CfgDataWidth-1:0] pattern_low;
  logic [CfgDataWidth-1:0] pattern_high;
  logic [PatternBits-1:0]  pattern;
  logic                    push_valid;
  logic                    push_ready;
  scan_op_t                push_op;
  logic                    pop_valid;
  logic                    pop_ready;
  scan_op_t                pop_op;

  assign pattern = {pattern_high, pattern_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode    <= MODE_FIND;
      pattern_length <= 5'd1;
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SEARCH_MODE:    search_mode    <= search_mode_t'(cfg_data[0]);
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lps_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .text           (text),
    .pattern_length (pattern_length),
    .pattern        (pattern),
    .op_valid       (push_valid),
    .op_ready       (push_ready),
    .op             (push_op)
  );

  lps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  lps_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (pop_valid),
    .op_ready    (pop_ready),
    .op          (pop_op),
    .search_mode (search_mode),
    .result      (result)
  );

endmodule

// ===== rtl/lps_front.sv =====
// Front end: accepts text bytes, keeps the line window and flags pattern hits.
module lps_front #(
  parameter int MAX_PATTERN = lps_pkg::MaxPatternDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  lps_text_if.sink                       text,
  input  logic [4:0]                     pattern_length,
  input  logic [lps_pkg::PatternBits-1:0] pattern,
  output logic                           op_valid,
  input  logic                           op_ready,
  output lps_pkg::scan_op_t              op
);
  import lps_pkg::*;

  localparam int FillWidth = $clog2(MAX_PATTERN + 1);
  localparam int IdxWidth = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [FillWidth-1:0]        fill;
  logic [FillWidth-1:0]        fill_next;
  logic [FillWidth-1:0]        eff_len;
  logic                        is_newline;
  logic                        hit;
  logic                        accept;

  assign is_newline = (text.text_byte == NEWLINE);
  assign text.ready = op_ready;
  assign op_valid   = text.valid;
  assign accept     = text.valid && op_ready;

  always_comb begin
    if (pattern_length == 5'd0) begin
      eff_len = FillWidth'(1);
    end else if (pattern_length > 5'(MAX_PATTERN)) begin
      eff_len = FillWidth'(MAX_PATTERN);
    end else begin
      eff_len = FillWidth'(pattern_length);
    end
  end

  always_comb begin
    logic [FillWidth-1:0] pos;
    pos = '0;
    window_next[0] = text.text_byte;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_next[j] = window[j-1];
    end
    fill_next = (fill == FillWidth'(MAX_PATTERN)) ? fill : fill + FillWidth'(1);
    hit = (fill_next >= eff_len) && !is_newline;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pos = eff_len - FillWidth'(1) - FillWidth'(k);
      if (FillWidth'(k) < eff_len) begin
        if (pattern[8*k +: 8] != window_next[pos[IdxWidth-1:0]]) begin
          hit = 1'b0;
        end
      end
    end
  end

  assign op.newline = is_newline;
  assign op.eof     = text.end_of_file;
  assign op.hit     = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      fill   <= '0;
    end else if (accept) begin
      if (is_newline || text.end_of_file) begin
        window <= '0;
        fill   <= '0;
      end else begin
        window <= window_next;
        fill   <= fill_next;
      end
    end
  end

endmodule

// ===== rtl/lps_queue.sv =====
// Short queue of classified bytes between the front end and the back end.
module lps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  lps_pkg::scan_op_t push_op,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lps_pkg::scan_op_t pop_op
);
  import lps_pkg::*;

  localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int LevelWidth = $clog2(QueueDepth + 1);

  scan_op_t              entries [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [LevelWidth-1:0] level;
  logic                  push;
  logic                  pop;

  assign push_ready = (level != LevelWidth'(QueueDepth));
  assign pop_valid  = (level != '0);
  assign pop_op     = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (push && !pop) begin
        level <= level + LevelWidth'(1);
      end else if (pop && !push) begin
        level <= level - LevelWidth'(1);
      end
    end
  end

endmodule

// ===== rtl/lps_back.sv =====
// Back end: line and occurrence counters and the registered result output.
`include "line_pattern_search_unit_macros.svh"

module lps_back #(
  parameter int COUNT_WIDTH = lps_pkg::CountWidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  op_valid,
  output logic                  op_ready,
  input  lps_pkg::scan_op_t     op,
  input  lps_pkg::search_mode_t search_mode,
  lps_result_if.source          result
);
  import lps_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [63:0] OutMax = 64'h0000_0000_FFFF_FFFF;

  logic [COUNT_WIDTH-1:0] current_line;
  logic [COUNT_WIDTH-1:0] current_line_next;
  logic [COUNT_WIDTH-1:0] line_occurrences;
  logic [COUNT_WIDTH-1:0] line_occurrences_next;
  logic [COUNT_WIDTH-1:0] total_occurrences;
  logic [COUNT_WIDTH-1:0] total_occurrences_next;
  logic                   search_finished;
  logic                   search_finished_next;
  logic [COUNT_WIDTH:0]   total_sum;
  logic                   emit;
  result_kind_t           kind_next;
  logic [OutWidth-1:0]    line_number_next;
  logic [OutWidth-1:0]    occurrence_count_next;
  logic                   step;

  function automatic logic [OutWidth-1:0] out_sat(input logic [COUNT_WIDTH-1:0] v);
    if (v > COUNT_WIDTH'(OutMax)) begin
      return '1;
    end
    return OutWidth'(v);
  endfunction

  assign op_ready = !result.valid || result.ready;
  assign step     = op_valid && op_ready;
  assign total_sum = {1'b0, total_occurrences} + {1'b0, line_occurrences};

  always_comb begin
    current_line_next      = current_line;
    line_occurrences_next  = line_occurrences;
    total_occurrences_next = total_occurrences;
    search_finished_next   = search_finished;
    emit                   = 1'b0;
    kind_next              = KIND_FIND;
    line_number_next       = '0;
    occurrence_count_next  = '0;
    if (op.newline) begin
      if (search_mode == MODE_FIND && !search_finished && line_occurrences != '0) begin
        emit                 = 1'b1;
        line_number_next     = out_sat(current_line);
        search_finished_next = 1'b1;
      end
      total_occurrences_next = total_sum[COUNT_WIDTH] ? CountMax
                                                      : total_sum[COUNT_WIDTH-1:0];
      line_occurrences_next  = '0;
      current_line_next      = (current_line == CountMax) ? current_line
                                                          : current_line + COUNT_WIDTH'(1);
    end else if (op.hit && line_occurrences != CountMax) begin
      line_occurrences_next = line_occurrences + COUNT_WIDTH'(1);
    end
    if (op.eof) begin
      if (search_mode == MODE_COUNT) begin
        emit                  = 1'b1;
        kind_next             = KIND_COUNT;
        line_number_next      = '0;
        occurrence_count_next = out_sat(total_occurrences_next);
      end
      current_line_next      = COUNT_WIDTH'(1);
      line_occurrences_next  = '0;
      total_occurrences_next = '0;
      search_finished_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_line      <= COUNT_WIDTH'(1);
      line_occurrences  <= '0;
      total_occurrences <= '0;
      search_finished   <= 1'b0;
      result.valid      <= 1'b0;
    end else begin
      if (step) begin
        current_line      <= current_line_next;
        line_occurrences  <= line_occurrences_next;
        total_occurrences <= total_occurrences_next;
        search_finished   <= search_finished_next;
        result.valid      <= emit;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result.result_kind      <= kind_next;
      result.line_number      <= line_number_next;
      result.occurrence_count <= occurrence_count_next;
    end
  end

  `LPS_ASSERT_NOW(a_count_has_no_line, result.valid && result.result_kind == KIND_COUNT, result.line_number == '0, "count result carries a line number")
  `LPS_ASSERT_NOW(a_find_has_line, result.valid && result.result_kind == KIND_FIND, result.occurrence_count == '0 && result.line_number != '0, "find result fields are inconsistent")
  `LPS_ASSERT_NEXT(a_eof_clears, step && op.eof, current_line == COUNT_WIDTH'(1) && total_occurrences == '0 && !search_finished, "end of file did not clear the counters")

endmodule
